// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mf3_pkg.sv -----
// shared types and constants of the 3x3 median filter
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int WIN        = 3;
  localparam int TAPS       = WIN * WIN;
  localparam int CNT_W      = $clog2(TAPS + 1);

  localparam int LINE_DEPTH = 2 * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int WREG_W     = 11;
  localparam int HREG_W     = 12;
  localparam int LEAD_W     = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD     = OUT_TDATA_W - PIX_W - ROW_W - COL_W;

  localparam int DEF_WIDTH  = 640;
  localparam int DEF_HEIGHT = 480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // item kinds on tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_ok_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    edge_ok_t         ok;
  } step_ctrl_t;

endpackage

// ----- hw/rtl/mf3_line_store.sv -----
// two-row pixel ring: one write port, two registered read ports
module mf3_line_store import mf3_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  pix_t              wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output pix_t              rd_data_a,
  output pix_t              rd_data_b
);

  pix_t mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // port a forwards a same-address write, port b returns the old entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (rd_addr_a == wr_addr)) begin
        rd_data_a <= wr_data;
      end else begin
        rd_data_a <= mem[rd_addr_a];
      end
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- hw/rtl/mf3_median.sv -----
// rank-based selection of the median over the in-bounds window taps
module mf3_median import mf3_pkg::*; (
  input  pix_t            taps [TAPS],
  input  logic [TAPS-1:0] tap_ok,
  output pix_t            median
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rank [TAPS];

  always_comb begin
    count = '0;
    for (int i = 0; i < TAPS; i++) begin
      count = count + CNT_W'(tap_ok[i]);
    end
    for (int i = 0; i < TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < TAPS; j++) begin
        if (j != i && tap_ok[j] &&
            ((taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i)))) begin
          rank[i] = rank[i] + CNT_W'(1);
        end
      end
    end
    median = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (tap_ok[i] && (rank[i] == (count >> 1))) begin
        median = taps[i];
      end
    end
  end

endmodule

// ----- hw/rtl/median_filter_3x3_top.sv -----
// top level of the 3x3 median filter
//
// pixels enter on s_axis in raster order: tuser low carries a pixel in tdata,
// tuser high is a drain beat. results leave on m_axis with the median, the
// centre row and column packed in tdata and tlast on the frame's last result.
// image size comes from the write port (width index 0, height index 1); any
// write restarts the frame. the user must ensure a write is only made while
// the filter is idle; the block does not enforce it. a result trails its input
// by width+1 pixels; after the frame's last pixel, one drain beat (or pixel
// beat, whose pixel is dropped) flushes one result. one beat is taken per
// cycle; the line store reads two rows and writes one pixel in the same cycle.
// a result passes line store read, window shift and median select to m_axis.
// reset restores 640x480, empties the pipeline and starts a new frame; the
// line store is not cleared, out-of-image taps are masked instead.
// when m_axis stalls the result register holds; the two inner stages keep
// taking beats until full, then s_axis_tready drops.
`include "assert_macros.svh"

module median_filter_3x3_top import mf3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel_value
  input  logic                   s_axis_tuser,   // [0] operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] median, [19:8] row, [29:20] column
  output logic                   m_axis_tlast    // frame_last
);

  // configuration, kept as size minus one
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic [WREG_W-1:0] w_raw;
  logic [HREG_W-1:0] h_raw;
  logic [COL_W-1:0]  wm1_new;
  logic [ROW_W-1:0]  hm1_new;
  logic [WREG_W-1:0] width;
  logic [LEAD_W-1:0] lead_full;

  // frame position state
  logic              draining;
  logic [LEAD_W-1:0] lead;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [ADDR_W-1:0] wp;

  logic acc;
  logic step;
  logic emit_now;
  logic last_pix;
  logic frame_end;
  logic [ADDR_W-1:0] off_mid;
  logic [ADDR_W-1:0] off_top;
  step_ctrl_t step_ctrl;

  // pipeline
  logic       s1_valid;
  step_ctrl_t s1_ctrl;
  pix_t       s1_pix;
  pix_t       rd_mid;
  pix_t       rd_top;
  logic       s2_valid;
  step_ctrl_t s2_ctrl;
  pix_t       win [WIN][WIN];
  logic       out_free;
  logic       s2_free;
  logic       s1_free;

  pix_t            taps [TAPS];
  logic [TAPS-1:0] tap_ok;
  logic [WIN-1:0]  col_ok;
  logic [WIN-1:0]  row_ok;
  pix_t            median;

  pix_t             res_med;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;

  // size decode for writes
  assign w_raw   = cfg_data[WREG_W-1:0];
  assign h_raw   = cfg_data[HREG_W-1:0];
  assign wm1_new = (w_raw == '0) ? '0 :
                   (32'(w_raw) > MAX_WIDTH) ? COL_W'(MAX_WIDTH - 1) :
                   COL_W'(w_raw - WREG_W'(1));
  assign hm1_new = (h_raw == '0) ? '0 : ROW_W'(h_raw - HREG_W'(1));

  assign width     = WREG_W'(wm1) + WREG_W'(1);
  assign lead_full = LEAD_W'(wm1) + LEAD_W'(2);

  // single-row images take the centre row one position later
  assign off_mid = (hm1 == '0) ? ADDR_W'(wm1) : ADDR_W'(width);
  assign off_top = ADDR_W'({width, 1'b0});

  assign acc       = s_axis_tvalid && s_axis_tready;
  assign step      = acc && (draining || (s_axis_tuser == OP_PIXEL));
  assign emit_now  = draining || (lead == lead_full);
  assign last_pix  = !draining && (in_row == hm1) && (in_col == wm1);
  assign frame_end = (out_row == hm1) && (out_col == wm1);

  always_comb begin
    step_ctrl.emit         = emit_now;
    step_ctrl.last         = frame_end;
    step_ctrl.row          = out_row;
    step_ctrl.col          = out_col;
    step_ctrl.ok.top       = (out_row != '0);
    step_ctrl.ok.bottom    = (out_row != hm1);
    step_ctrl.ok.left      = (out_col != '0);
    step_ctrl.ok.right     = (out_col != wm1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1      <= COL_W'(DEF_WIDTH - 1);
      hm1      <= ROW_W'(DEF_HEIGHT - 1);
      draining <= 1'b0;
      lead     <= '0;
      in_row   <= '0;
      in_col   <= '0;
      out_row  <= '0;
      out_col  <= '0;
      wp       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  wm1 <= wm1_new;
        REG_HEIGHT: hm1 <= hm1_new;
      endcase
      draining <= 1'b0;
      lead     <= '0;
      in_row   <= '0;
      in_col   <= '0;
      out_row  <= '0;
      out_col  <= '0;
    end else if (step) begin
      wp <= wp + ADDR_W'(1);
      if (!draining) begin
        if (last_pix) begin
          draining <= 1'b1;
          in_row   <= '0;
          in_col   <= '0;
        end else if (in_col == wm1) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (!emit_now) begin
          lead <= lead + LEAD_W'(1);
        end
      end
      if (emit_now) begin
        if (draining && frame_end) begin
          draining <= 1'b0;
          lead     <= '0;
          out_row  <= '0;
          out_col  <= '0;
        end else if (out_col == wm1) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  mf3_line_store u_line_store (
    .clk       (clk),
    .wr_en     (step),
    .wr_addr   (wp),
    .wr_data   (s_axis_tdata),
    .rd_en     (step),
    .rd_addr_a (wp - off_mid),
    .rd_addr_b (wp - off_top),
    .rd_data_a (rd_mid),
    .rd_data_b (rd_top)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s2_free       = !s2_valid || out_free;
  assign s1_free       = !s1_valid || s2_free;
  assign s_axis_tready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= step;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        m_axis_tvalid <= s2_valid && s2_ctrl.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_ctrl <= step_ctrl;
      s1_pix  <= s_axis_tdata;
    end
    if (s2_free && s1_valid) begin
      s2_ctrl   <= s1_ctrl;
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= rd_top;
      win[2][1] <= rd_mid;
      win[2][2] <= s1_pix;
    end
    if (out_free && s2_valid && s2_ctrl.emit) begin
      res_med      <= median;
      res_row      <= s2_ctrl.row;
      res_col      <= s2_ctrl.col;
      m_axis_tlast <= s2_ctrl.last;
    end
  end

  // window taps, column major: left, centre, right
  assign col_ok = {s2_ctrl.ok.right, 1'b1, s2_ctrl.ok.left};
  assign row_ok = {s2_ctrl.ok.bottom, 1'b1, s2_ctrl.ok.top};

  always_comb begin
    for (int c = 0; c < WIN; c++) begin
      for (int r = 0; r < WIN; r++) begin
        taps[c * WIN + r]   = win[c][r];
        tap_ok[c * WIN + r] = col_ok[c] && row_ok[r];
      end
    end
  end

  mf3_median u_median (
    .taps   (taps),
    .tap_ok (tap_ok),
    .median (median)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, res_col, res_row, res_med};

  `ASSERT_CLK(a_cols_in_range, (in_col <= wm1) && (out_col <= wm1), "column counter beyond width")
  `ASSERT_CLK(a_drain_beat_steps, (acc && draining) |=> s1_valid, "drain beat did not advance")
  `ASSERT_CLK(a_emit_reaches_out, (s2_valid && s2_ctrl.emit && out_free) |=> m_axis_tvalid, "result lost before output")
  `ASSERT_CLK_ALWAYS(a_ready_blocked_by_s1, !s_axis_tready |-> s1_valid, "input blocked with stage one empty")

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench of the 3x3 median filter: predicts each median and checks the stream
`timescale 1ns / 100ps

module tb_top;
  import mf3_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_WIDTH + 4;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } median_res_t;

  class median_checker;
    int unsigned width_reg;
    int unsigned height_reg;
    pix_t        line_copy[RING_DEPTH];
    int unsigned in_row;
    int unsigned in_col;
    int unsigned out_pos;
    int unsigned owed_results;
    median_res_t due_medians[$];
    int          errors;

    function new();
      width_reg = DEF_WIDTH;
      height_reg = DEF_HEIGHT;
      foreach (line_copy[i]) line_copy[i] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_row = 0;
      in_col = 0;
      out_pos = 0;
      owed_results = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      if (idx == REG_WIDTH) width_reg = val & 32'h7FF;
      else height_reg = val & 32'hFFF;
      restart();
    endfunction

    function void predict_median(int unsigned w, int unsigned h, int unsigned q);
      int unsigned cr, cc, cnt;
      int          r, c, j;
      pix_t        win[TAPS];
      pix_t        v;
      median_res_t res;
      cr = q / w;
      cc = q % w;
      cnt = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          r = int'(cr) + dr;
          c = int'(cc) + dc;
          if (r < 0 || r >= int'(h) || c < 0 || c >= int'(w)) continue;
          win[cnt] = line_copy[(r * int'(w) + c) % RING_DEPTH];
          cnt++;
        end
      end
      for (int i = 1; i < int'(cnt); i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      res.median = win[cnt/2];
      res.row = cr[ROW_W-1:0];
      res.col = cc[COL_W-1:0];
      res.last = (q == w * h - 1);
      due_medians.push_back(res);
    endfunction

    // returns 1 when the beat changed the state
    function bit accept_beat(logic op, pix_t pix);
      int unsigned w, h, total, p, n;
      w = eff_width();
      h = eff_height();
      total = w * h;
      if (op == OP_PIXEL && owed_results == 0) begin
        p = in_row * w + in_col;
        n = p + 1;
        line_copy[p % RING_DEPTH] = pix;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
        if (n >= w + 2) begin
          predict_median(w, h, out_pos);
          out_pos++;
        end
        if (n >= total) begin
          owed_results = total - out_pos;
          if (owed_results == 0) restart();
        end
        return 1;
      end
      if (owed_results == 0) return 0;
      predict_median(w, h, out_pos);
      out_pos++;
      owed_results--;
      if (owed_results == 0) restart();
      return 1;
    endfunction

    function void compare_result(logic [OUT_TDATA_W-1:0] data, logic last);
      median_res_t want;
      if (due_medians.size() == 0) begin
        errors++;
        $display("%0t: unexpected result median %0d row %0d column %0d last %b", $time,
                 data[PIX_W-1:0], data[PIX_W +: ROW_W], data[PIX_W+ROW_W +: COL_W], last);
        return;
      end
      want = due_medians.pop_front();
      if (data[PIX_W-1:0] !== want.median) begin
        errors++;
        $display("%0t: median at row %0d column %0d expected %0d actual %0d", $time,
                 want.row, want.col, want.median, data[PIX_W-1:0]);
      end
      if (data[PIX_W +: ROW_W] !== want.row) begin
        errors++;
        $display("%0t: row expected %0d actual %0d", $time, want.row, data[PIX_W +: ROW_W]);
      end
      if (data[PIX_W+ROW_W +: COL_W] !== want.col) begin
        errors++;
        $display("%0t: column expected %0d actual %0d", $time, want.col,
                 data[PIX_W+ROW_W +: COL_W]);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last expected %b actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  median_checker sb;
  int            src_idle = 0;
  int            sink_idle = 0;
  int unsigned   beats_taken = 0;
  int unsigned   cycle_count = 0;

  median_filter_3x3_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle);
      if (m_axis_tvalid && m_axis_tready) sb.compare_result(m_axis_tdata, m_axis_tlast);
    end
  end

  function pix_t rand_pix();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  task send_beat(input logic op, input pix_t pix);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= pix;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (sb.accept_beat(op, pix)) beats_taken++;
  endtask

  // hold the input until every median is out and the pipeline is empty
  task settle();
    s_axis_tvalid <= 1'b0;
    while (sb.due_medians.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task set_geometry(input int unsigned w_reg, input int unsigned h_reg);
    cfg_write <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w_reg[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h_reg[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(REG_WIDTH, w_reg);
    sb.write_reg(REG_HEIGHT, h_reg);
  endtask

  task run_frames(input int unsigned w_reg, input int unsigned h_reg,
                  input int unsigned pix_cap);
    int unsigned total, target, frames;
    bit          cut;
    set_geometry(w_reg, h_reg);
    total = sb.eff_width() * sb.eff_height();
    frames = (pix_cap != 0) ? 1 : $urandom_range(1, 2);
    for (int f = 0; f < int'(frames); f++) begin
      cut = (pix_cap != 0) || ($urandom_range(6) == 0);
      target = (pix_cap != 0) ? pix_cap : (cut ? $urandom_range(1, total) : total);
      for (int i = 0; i < int'(target); i++) begin
        if ($urandom_range(19) == 0) send_beat(OP_DRAIN, rand_pix());
        send_beat(OP_PIXEL, rand_pix());
        if ($urandom_range(199) == 0) settle();
      end
      while (sb.owed_results != 0)
        send_beat(($urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN, rand_pix());
      if ($urandom_range(4) == 0) send_beat(OP_DRAIN, rand_pix());
      if (cut) break;
    end
    settle();
  endtask

  initial begin
    pix_t        dir_pix[9];
    int unsigned rand_beats, mark, w_reg, h_reg;
    bit          extremes_done;
    dir_pix = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'd127, 8'd0, 8'd255, 8'd0};
    rand_beats = 0;
    extremes_done = 1'b0;
    sb = new();
    src_idle = 38;
    sink_idle = 77;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default geometry after reset
    repeat (650) send_beat(OP_PIXEL, rand_pix());
    settle();

    // 3x3 frame: drain with nothing owed, pause mid-frame, pixel while owed
    set_geometry(3, 3);
    send_beat(OP_DRAIN, 8'hFF);
    for (int i = 0; i < 9; i++) begin
      send_beat(OP_PIXEL, dir_pix[i]);
      if (i == 5) settle();
    end
    send_beat(OP_DRAIN, 8'h00);
    send_beat(OP_DRAIN, 8'h55);
    send_beat(OP_PIXEL, 8'hAA);
    send_beat(OP_DRAIN, 8'h00);
    send_beat(OP_DRAIN, 8'h00);
    settle();

    // single column, then zero width and height acting as one
    set_geometry(1, 3);
    send_beat(OP_PIXEL, 8'd9);
    send_beat(OP_PIXEL, 8'd200);
    send_beat(OP_PIXEL, 8'd17);
    send_beat(OP_DRAIN, 8'd0);
    send_beat(OP_DRAIN, 8'd0);
    settle();
    set_geometry(0, 0);
    send_beat(OP_PIXEL, 8'h5A);
    send_beat(OP_PIXEL, 8'hA5);
    settle();

    while (rand_beats < 1800) begin
      if (rand_beats < 600) begin
        src_idle = 38;
        sink_idle = 77;
      end else if (rand_beats < 1200) begin
        src_idle = 77;
        sink_idle = 38;
      end else begin
        src_idle = 0;
        sink_idle = 0;
      end
      if (!extremes_done && rand_beats >= 600) begin
        // saturated width, full-width rows across the line store, tallest frame
        run_frames(2047, 2, 1040);
        run_frames(MAX_WIDTH, 4095, 2100);
        run_frames(1, 4095, 40);
        extremes_done = 1'b1;
      end
      case ($urandom_range(9))
        0: w_reg = 0;
        1: w_reg = 1;
        2: w_reg = 2;
        3: w_reg = $urandom_range(13, 40);
        default: w_reg = $urandom_range(3, 12);
      endcase
      case ($urandom_range(7))
        0: h_reg = 0;
        1: h_reg = 1;
        default: h_reg = $urandom_range(2, 8);
      endcase
      mark = beats_taken;
      run_frames(w_reg, h_reg, 0);
      rand_beats += beats_taken - mark;
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due_medians.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_line_store.sv
hw/rtl/mf3_median.sv
hw/rtl/median_filter_3x3_top.sv
tb/tb_top.sv
